/* hdl/irig_j_time_code_formatter_unit_defines.svh */
// Assertion macros for the IRIG J time code formatter RTL.
`ifndef IRIG_J_TIME_CODE_FORMATTER_UNIT_DEFINES_SVH
`define IRIG_J_TIME_CODE_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IJTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ijtc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IJTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ijtc next-cycle check failed");

`endif

/* hdl/ijtc_pkg.sv */
// Shared types, constants and the microcode program of the IRIG J formatter.
package ijtc_pkg;

  localparam int STEP_W = 6;
  localparam int SOD_W  = 17;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [3:0]        op_t;
  typedef logic [3:0]        kind_t;
  typedef logic [1:0]        jump_t;
  typedef logic [6:0]        char_t;

  // Datapath operations.
  localparam op_t OP_WAIT_IN  = 4'd0;
  localparam op_t OP_EMIT_LIT = 4'd1;
  localparam op_t OP_EMIT_QUO = 4'd2;
  localparam op_t OP_EMIT_ACC = 4'd3;
  localparam op_t OP_LDDV     = 4'd4;
  localparam op_t OP_CSUB     = 4'd5;
  localparam op_t OP_XFER     = 4'd6;
  localparam op_t OP_INC      = 4'd7;
  localparam op_t OP_LOAD_SV  = 4'd8;
  localparam op_t OP_SWAP     = 4'd9;
  localparam op_t OP_NOP      = 4'd10;

  // Divisor kinds: each picks a constant, an iteration count and a mode.
  localparam kind_t K_NONE = 4'd0;
  localparam kind_t K_DAY  = 4'd1;
  localparam kind_t K_400Y = 4'd2;
  localparam kind_t K_100Y = 4'd3;
  localparam kind_t K_4Y   = 4'd4;
  localparam kind_t K_1Y   = 4'd5;
  localparam kind_t K_100  = 4'd6;
  localparam kind_t K_10   = 4'd7;
  localparam kind_t K_HR   = 4'd8;
  localparam kind_t K_MIN  = 4'd9;

  // Sequencing after a step completes.
  localparam jump_t JMP_NEXT      = 2'd0;
  localparam jump_t JMP_ALWAYS    = 2'd1;
  localparam jump_t JMP_NO_TENTHS = 2'd2;

  localparam int SECS_PER_DAY      = 86400;
  localparam int DAYS_PER_400Y     = 146097;
  localparam int DAYS_PER_100Y     = 36524;
  localparam int DAYS_PER_4Y       = 1461;
  localparam int DAYS_PER_1Y       = 365;
  localparam int DAYS_1601_TO_1970 = 134774;
  localparam int SECS_PER_HOUR     = 3600;
  localparam int SECS_PER_MIN      = 60;

  localparam char_t CH_SOH   = 7'h01;
  localparam char_t CH_COLON = 7'h3A;
  localparam char_t CH_DOT   = 7'h2E;
  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_CR    = 7'h0D;
  localparam char_t CH_LF    = 7'h0A;

  localparam step_t STEP_CR   = 6'd47;
  localparam step_t LAST_STEP = 6'd48;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    char_t chr;
    logic  last;
    jump_t jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    uword_t word;
    logic   go;
  } dp_ctl_t;

  typedef struct packed {
    logic loop_done;
    logic out_free;
  } dp_stat_t;

  function automatic uword_t uw(op_t op, kind_t kind, char_t chr, logic last,
                                jump_t jmp, step_t target);
    uword_t w;
    w.op     = op;
    w.kind   = kind;
    w.chr    = chr;
    w.last   = last;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t op_only(op_t op, kind_t kind);
    return uw(op, kind, CH_SOH, 1'b0, JMP_NEXT, '0);
  endfunction

  function automatic uword_t emit(char_t chr);
    return uw(OP_EMIT_LIT, K_NONE, chr, 1'b0, JMP_NEXT, '0);
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      6'd0:  w = op_only(OP_WAIT_IN, K_NONE);
      6'd1:  w = emit(CH_SOH);
      6'd2:  w = op_only(OP_LDDV, K_DAY);
      6'd3:  w = op_only(OP_CSUB, K_DAY);
      6'd4:  w = op_only(OP_XFER, K_NONE);
      6'd5:  w = op_only(OP_LDDV, K_400Y);
      6'd6:  w = op_only(OP_CSUB, K_400Y);
      6'd7:  w = op_only(OP_LDDV, K_100Y);
      6'd8:  w = op_only(OP_CSUB, K_100Y);
      6'd9:  w = op_only(OP_LDDV, K_4Y);
      6'd10: w = op_only(OP_CSUB, K_4Y);
      6'd11: w = op_only(OP_LDDV, K_1Y);
      6'd12: w = op_only(OP_CSUB, K_1Y);
      6'd13: w = op_only(OP_INC, K_NONE);
      6'd14: w = op_only(OP_LDDV, K_100);
      6'd15: w = op_only(OP_CSUB, K_100);
      6'd16: w = op_only(OP_EMIT_QUO, K_NONE);
      6'd17: w = op_only(OP_LDDV, K_10);
      6'd18: w = op_only(OP_CSUB, K_10);
      6'd19: w = op_only(OP_EMIT_QUO, K_NONE);
      6'd20: w = op_only(OP_EMIT_ACC, K_NONE);
      6'd21: w = emit(CH_COLON);
      6'd22: w = op_only(OP_LOAD_SV, K_NONE);
      6'd23: w = op_only(OP_LDDV, K_HR);
      6'd24: w = op_only(OP_CSUB, K_HR);
      6'd25: w = op_only(OP_SWAP, K_NONE);
      6'd26: w = op_only(OP_LDDV, K_10);
      6'd27: w = op_only(OP_CSUB, K_10);
      6'd28: w = op_only(OP_EMIT_QUO, K_NONE);
      6'd29: w = op_only(OP_EMIT_ACC, K_NONE);
      6'd30: w = emit(CH_COLON);
      6'd31: w = op_only(OP_LOAD_SV, K_NONE);
      6'd32: w = op_only(OP_LDDV, K_MIN);
      6'd33: w = op_only(OP_CSUB, K_MIN);
      6'd34: w = op_only(OP_SWAP, K_NONE);
      6'd35: w = op_only(OP_LDDV, K_10);
      6'd36: w = op_only(OP_CSUB, K_10);
      6'd37: w = op_only(OP_EMIT_QUO, K_NONE);
      6'd38: w = op_only(OP_EMIT_ACC, K_NONE);
      6'd39: w = emit(CH_COLON);
      6'd40: w = op_only(OP_LOAD_SV, K_NONE);
      6'd41: w = op_only(OP_LDDV, K_10);
      6'd42: w = op_only(OP_CSUB, K_10);
      6'd43: w = op_only(OP_EMIT_QUO, K_NONE);
      6'd44: w = uw(OP_EMIT_ACC, K_NONE, CH_SOH, 1'b0, JMP_NO_TENTHS, STEP_CR);
      6'd45: w = emit(CH_DOT);
      6'd46: w = emit(CH_ZERO);
      6'd47: w = emit(CH_CR);
      6'd48: w = uw(OP_EMIT_LIT, K_NONE, CH_LF, 1'b1, JMP_ALWAYS, '0);
      default: w = uw(OP_NOP, K_NONE, CH_SOH, 1'b0, JMP_ALWAYS, '0);
    endcase
    return w;
  endfunction

endpackage

/* hdl/ijtc_seq.sv */
// Microcode sequencer: step counter, control store and jump logic.
module ijtc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               tenths,
  input  ijtc_pkg::dp_stat_t stat,
  output ijtc_pkg::dp_ctl_t  ctl
);

  ijtc_pkg::step_t  step_r;
  ijtc_pkg::step_t  step_nxt;
  ijtc_pkg::step_t  step_inc;
  ijtc_pkg::uword_t word;
  logic             go;
  logic             done;

  assign word     = ijtc_pkg::ucode(step_r);
  assign step_inc = step_r + ijtc_pkg::step_t'(1);
  assign in_ready = (word.op == ijtc_pkg::OP_WAIT_IN);

  always_comb begin
    unique case (word.op) inside
      ijtc_pkg::OP_WAIT_IN: go = in_valid;
      ijtc_pkg::OP_EMIT_LIT, ijtc_pkg::OP_EMIT_QUO, ijtc_pkg::OP_EMIT_ACC: go = stat.out_free;
      default: go = 1'b1;
    endcase
  end

  // A subtract loop holds its step until the iteration count runs out.
  assign done = go && ((word.op != ijtc_pkg::OP_CSUB) || stat.loop_done);

  always_comb begin
    step_nxt = step_r;
    if (done) begin
      unique case (word.jmp)
        ijtc_pkg::JMP_ALWAYS:    step_nxt = word.target;
        ijtc_pkg::JMP_NO_TENTHS: step_nxt = tenths ? step_inc : word.target;
        default:                 step_nxt = step_inc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.word = word;
  assign ctl.go   = go;

endmodule

/* hdl/ijtc_dp.sv */
// Datapath: accumulator, divisor, quotient, save register and output stage.
module ijtc_dp #(
  parameter int SECONDS_WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ijtc_pkg::dp_ctl_t        ctl,
  input  logic [SECONDS_WIDTH-1:0] in_secs,
  output ijtc_pkg::dp_stat_t       stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [6:0]               out_char,
  output logic                     out_last
);

  localparam int DW   = SECONDS_WIDTH;
  localparam int QB   = DW - 16;               // day quotient bits
  localparam int DB   = ((QB > 18) ? QB : 18) + 1;  // day count bits after offset
  localparam int N400 = DB - 17;               // quotient bits of the 400-year step
  localparam int CW   = $clog2(QB);
  localparam int SW   = ijtc_pkg::SOD_W;

  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [QB-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sv_r, sv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic [DW-1:0] dv_init;
  logic [CW-1:0] cnt_init;
  logic          dv_shift;
  logic          ge;
  logic [DW-1:0] diff;
  logic          out_free;

  // Divisor table: shifted kinds run a restoring division, the others
  // subtract a fixed amount up to three times, which also clamps.
  always_comb begin
    unique case (ctl.word.kind)
      ijtc_pkg::K_DAY: begin
        dv_init  = DW'(ijtc_pkg::SECS_PER_DAY) << (QB - 1);
        cnt_init = CW'(QB - 1);
        dv_shift = 1'b1;
      end
      ijtc_pkg::K_400Y: begin
        dv_init  = DW'(ijtc_pkg::DAYS_PER_400Y) << (N400 - 1);
        cnt_init = CW'(N400 - 1);
        dv_shift = 1'b1;
      end
      ijtc_pkg::K_100Y: begin
        dv_init  = DW'(ijtc_pkg::DAYS_PER_100Y);
        cnt_init = CW'(2);
        dv_shift = 1'b0;
      end
      ijtc_pkg::K_4Y: begin
        dv_init  = DW'(ijtc_pkg::DAYS_PER_4Y) << 4;
        cnt_init = CW'(4);
        dv_shift = 1'b1;
      end
      ijtc_pkg::K_1Y: begin
        dv_init  = DW'(ijtc_pkg::DAYS_PER_1Y);
        cnt_init = CW'(2);
        dv_shift = 1'b0;
      end
      ijtc_pkg::K_100: begin
        dv_init  = DW'(100);
        cnt_init = CW'(2);
        dv_shift = 1'b0;
      end
      ijtc_pkg::K_10: begin
        dv_init  = DW'(10) << 3;
        cnt_init = CW'(3);
        dv_shift = 1'b1;
      end
      ijtc_pkg::K_HR: begin
        dv_init  = DW'(ijtc_pkg::SECS_PER_HOUR) << 4;
        cnt_init = CW'(4);
        dv_shift = 1'b1;
      end
      ijtc_pkg::K_MIN: begin
        dv_init  = DW'(ijtc_pkg::SECS_PER_MIN) << 5;
        cnt_init = CW'(5);
        dv_shift = 1'b1;
      end
      default: begin
        dv_init  = '0;
        cnt_init = '0;
        dv_shift = 1'b0;
      end
    endcase
  end

  assign ge       = (acc_r >= dv_r);
  assign diff     = acc_r - dv_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    acc_nxt       = acc_r;
    dv_nxt        = dv_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    sv_nxt        = sv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (ctl.go) begin
      unique case (ctl.word.op)
        ijtc_pkg::OP_WAIT_IN: acc_nxt = in_secs;
        ijtc_pkg::OP_LDDV: begin
          dv_nxt  = dv_init;
          cnt_nxt = cnt_init;
          quo_nxt = '0;
        end
        ijtc_pkg::OP_CSUB: begin
          if (ge) begin
            acc_nxt = diff;
          end
          if (dv_shift) begin
            quo_nxt = {quo_r[QB-2:0], ge};
            dv_nxt  = dv_r >> 1;
          end else begin
            quo_nxt = quo_r + QB'(ge);
          end
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        ijtc_pkg::OP_XFER: begin
          sv_nxt  = acc_r[SW-1:0];
          acc_nxt = DW'(quo_r) + DW'(ijtc_pkg::DAYS_1601_TO_1970);
        end
        ijtc_pkg::OP_INC:     acc_nxt = acc_r + DW'(1);
        ijtc_pkg::OP_LOAD_SV: acc_nxt = DW'(sv_r);
        ijtc_pkg::OP_SWAP: begin
          sv_nxt  = acc_r[SW-1:0];
          acc_nxt = DW'(quo_r);
        end
        ijtc_pkg::OP_EMIT_LIT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ctl.word.chr;
          out_last_nxt  = ctl.word.last;
        end
        ijtc_pkg::OP_EMIT_QUO: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ijtc_pkg::CH_ZERO + 7'(quo_r[3:0]);
          out_last_nxt  = ctl.word.last;
        end
        ijtc_pkg::OP_EMIT_ACC: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ijtc_pkg::CH_ZERO + 7'(acc_r[3:0]);
          out_last_nxt  = ctl.word.last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    dv_r       <= dv_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    sv_r       <= sv_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.loop_done = (cnt_r == '0);
  assign stat.out_free  = out_free;
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last       = out_last_r;

endmodule

/* hdl/irig_j_time_code_formatter_unit.sv */
// Start: after an accept the step counter moves to the SOH step, which loads SOH into the
//   output register once that register is free. One request is handled at a time; the
//   next is taken when the program returns to its wait step, and out_ready stalls hold it.
//   The pace is set by the single shared compare-subtract unit, one quotient bit a cycle.
// Reset: rst_n (synchronous) clears the step counter and output valid and sets
//   include_tenths to 1.
`include "irig_j_time_code_formatter_unit_defines.svh"

module irig_j_time_code_formatter_unit #(
  parameter int SECONDS_WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Request channel: one PPS-latched seconds count per request.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SECONDS_WIDTH-1:0] in_epoch_seconds,
  // Result channel: one ASCII character per transfer.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [6:0]               out_char_code,
  output logic                     out_last_char,
  // Register port, one register (include_tenths) at byte address 0.
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [2:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  // The program splits the count into days and second of day, folds the
  // day count (offset to 1601) through the 400/100/4/1-year cycles to get
  // the day of year, then peels hours, minutes and seconds and turns each
  // into decimal digits, sending every character as soon as it is known.

  logic               tenths_r;
  logic               tenths_nxt;
  logic               cfg_wr;
  ijtc_pkg::dp_ctl_t  ctl;
  ijtc_pkg::dp_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Only the word at index 0 exists; other addresses read zero and drop writes.
  always_comb begin
    tenths_nxt = tenths_r;
    if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      tenths_nxt = cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'b0, tenths_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenths_r <= 1'b1;
    end else begin
      tenths_r <= tenths_nxt;
    end
  end

  // Control store and step counter.
  ijtc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .tenths   (tenths_r),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Shared compare-subtract datapath and output register.
  ijtc_dp #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_secs   (in_epoch_seconds),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_char  (out_char_code),
    .out_last  (out_last_char)
  );

  // One request in flight: the cycle after an accept the program is busy.
  `IJTC_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
  // The flagged character is always the line feed.
  `IJTC_ASSERT_NOW(a_last_is_lf, out_valid && out_last_char, out_char_code == ijtc_pkg::CH_LF)
  // Every subtract loop is armed with more than one iteration.
  `IJTC_ASSERT_NEXT(a_loop_armed, ctl.go && (ctl.word.op == ijtc_pkg::OP_LDDV), !stat.loop_done)

endmodule
